### hdl/utf8v_pkg.sv
// shared types, byte codes and limits for the utf-8 validator
package utf8v_pkg;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 3;
    localparam int CP_W        = 21;

    localparam logic [7:0] BYTE_TAB     = 8'h09;
    localparam logic [7:0] BYTE_SPACE   = 8'h20;
    localparam logic [7:0] BYTE_DEL     = 8'h7f;
    localparam logic [7:0] LEAD2_LO     = 8'hc2;
    localparam logic [7:0] LEAD2_HI     = 8'hdf;
    localparam logic [7:0] LEAD3_LO     = 8'he0;
    localparam logic [7:0] LEAD3_HI     = 8'hef;
    localparam logic [7:0] LEAD4_LO     = 8'hf0;
    localparam logic [7:0] LEAD4_HI     = 8'hf4;
    localparam logic [1:0] CONT_TAG     = 2'b10;

    localparam logic [CP_W-1:0] CP_MIN2      = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN3      = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN4      = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10ffff;
    localparam logic [CP_W-1:0] SURR_LO      = 21'h00d800;
    localparam logic [CP_W-1:0] SURR_HI      = 21'h00dfff;

    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_CONTROL = 2'd1,
        ERR_INVALID = 2'd2
    } t_err;

    typedef struct packed {
        logic [1:0]      pending;
        logic [2:0]      seq_len;
        logic [CP_W-1:0] accum;
        t_err            err;
    } t_dec_state;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            char_done;
        logic [1:0]      error_kind;
        logic            string_end;
    } t_dec_result;

endpackage

### hdl/utf8_validator.sv
// top level of the streaming utf-8 validator: input register, decode, result register
//
//  channel  | dir | tdata                 | tuser                           | tlast
//  s_axis   | in  | [7:0] byte_value      | -                               | last_byte
//  m_axis   | out | [20:0] code_point     | [0] char_done, [2:1] error_kind | string_end
//
//  one beat per cycle sustained while the output is not stalled; a byte passes through the
//  input register, then the result register
//  decode state advances when a beat moves from the input register to the result register
//  reset clears both valid flags and the sequence state; payload registers are not reset
//  a stalled output holds its beat; the input register still takes a beat while it is empty
module utf8_validator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [utf8v_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,   // [7:0] byte_value
    input  logic                                 i_s_axis_tlast,   // last_byte
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [utf8v_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,   // [20:0] code_point, zero pad
    output logic [utf8v_pkg::OUT_TUSER_W-1:0]    o_m_axis_tuser,   // [0] char_done, [2:1] error_kind
    output logic                                 o_m_axis_tlast    // string_end
);
    import utf8v_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    t_dec_state  r_state;
    t_dec_state  n_state;
    logic        r_out_valid;
    t_dec_result r_out;
    t_dec_result n_out;
    logic        w_adv;

    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;

    utf8v_decode u_decode (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata[7:0];
            r_in_last <= i_s_axis_tlast;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-CP_W){1'b0}}, r_out.code_point};
    assign o_m_axis_tuser  = {r_out.error_kind, r_out.char_done};
    assign o_m_axis_tlast  = r_out.string_end;

    // a sequence in progress means no error has been latched
    a_pending_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.pending != 2'd0) |-> (r_state.err == ERR_NONE))
        else $error("pending continuation bytes with a latched error");

    a_pending_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.pending != 2'd0) |-> ({1'b0, r_state.pending} < r_state.seq_len))
        else $error("pending count not below sequence length");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> (r_state == '0))
        else $error("state not cleared after last byte");

    a_done_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.char_done) |-> (r_out.error_kind == ERR_NONE))
        else $error("completed character with an error reported");

    a_cp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.char_done) |-> (r_out.code_point == '0))
        else $error("code point nonzero without a completed character");

endmodule

### hdl/utf8v_decode.sv
// per-byte decode: next sequence state and the result beat for one byte
module utf8v_decode (
    input  utf8v_pkg::t_dec_state  i_state,
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    output utf8v_pkg::t_dec_state  o_state,
    output utf8v_pkg::t_dec_result o_result
);
    import utf8v_pkg::*;

    logic [CP_W-1:0] w_acc_shift;
    logic [CP_W-1:0] w_min;
    logic            w_scalar_ok;
    t_dec_state      w_next;
    logic [CP_W-1:0] w_cp;
    logic            w_done;

    assign w_acc_shift = {i_state.accum[CP_W-7:0], i_byte[5:0]};

    always_comb begin
        unique case (i_state.seq_len)
            SEQ_LEN2: w_min = CP_MIN2;
            SEQ_LEN3: w_min = CP_MIN3;
            default:  w_min = CP_MIN4;
        endcase
        w_scalar_ok = (w_acc_shift >= w_min) && (w_acc_shift <= CP_MAX)
                   && !((w_acc_shift >= SURR_LO) && (w_acc_shift <= SURR_HI));
    end

    always_comb begin
        w_next = i_state;
        w_cp   = '0;
        w_done = 1'b0;
        if (i_state.err == ERR_NONE) begin
            if (i_state.pending == 2'd0) begin
                if (!i_byte[7]) begin
                    if ((i_byte < BYTE_SPACE && i_byte != BYTE_TAB) || i_byte == BYTE_DEL) begin
                        w_next.err = ERR_CONTROL;
                    end else begin
                        w_cp   = {{(CP_W-8){1'b0}}, i_byte};
                        w_done = 1'b1;
                    end
                end else if (i_byte >= LEAD2_LO && i_byte <= LEAD2_HI) begin
                    w_next.accum   = {{(CP_W-5){1'b0}}, i_byte[4:0]};
                    w_next.seq_len = SEQ_LEN2;
                    w_next.pending = 2'd1;
                end else if (i_byte >= LEAD3_LO && i_byte <= LEAD3_HI) begin
                    w_next.accum   = {{(CP_W-4){1'b0}}, i_byte[3:0]};
                    w_next.seq_len = SEQ_LEN3;
                    w_next.pending = 2'd2;
                end else if (i_byte >= LEAD4_LO && i_byte <= LEAD4_HI) begin
                    w_next.accum   = {{(CP_W-3){1'b0}}, i_byte[2:0]};
                    w_next.seq_len = SEQ_LEN4;
                    w_next.pending = 2'd3;
                end else begin
                    w_next.err = ERR_INVALID;
                end
            end else if (i_byte[7:6] != CONT_TAG) begin
                w_next.err = ERR_INVALID;
            end else begin
                w_next.accum   = w_acc_shift;
                w_next.pending = i_state.pending - 2'd1;
                // final continuation byte: range, overlong and surrogate check
                if (i_state.pending == 2'd1) begin
                    if (w_scalar_ok) begin
                        w_cp   = w_acc_shift;
                        w_done = 1'b1;
                    end else begin
                        w_next.err = ERR_INVALID;
                    end
                end
            end
            if (w_next.err != ERR_NONE) begin
                w_next.pending = '0;
                w_next.seq_len = '0;
                w_next.accum   = '0;
            end
        end
        // string ends in the middle of a sequence
        if (i_last && w_next.err == ERR_NONE && w_next.pending != 2'd0) begin
            w_next.err = ERR_INVALID;
        end
    end

    always_comb begin
        o_result.code_point = w_cp;
        o_result.char_done  = w_done;
        o_result.error_kind = w_next.err;
        o_result.string_end = i_last;
        o_state             = i_last ? '0 : w_next;
    end

endmodule

### verif/utf8_validator_checker.sv
`timescale 1ns / 1ps
// utf-8 validator checker: byte decoder model plus in-order compare of result beats
module utf8_validator_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    input  logic                              i_s_axis_tready,
    input  logic [utf8v_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,   // [7:0] byte_value
    input  logic                              i_s_axis_tlast,   // last_byte
    input  logic                              i_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [utf8v_pkg::OUT_TDATA_W-1:0] i_m_axis_tdata,   // [20:0] code_point, zero pad
    input  logic [utf8v_pkg::OUT_TUSER_W-1:0] i_m_axis_tuser,   // [0] char_done, [2:1] error_kind
    input  logic                              i_m_axis_tlast,   // string_end
    output int                                o_fail_count,
    output int                                o_outstanding
);
    import utf8v_pkg::*;

    // decoder state of the string in flight
    logic [1:0]      cont_left;
    logic [2:0]      seq_len;
    logic [CP_W-1:0] cp_accum;
    t_err            first_err;

    t_dec_result     decoded_q[$];
    int              fails;

    task automatic clear_decoder();
        cont_left = 2'd0;
        seq_len   = 3'd0;
        cp_accum  = '0;
        first_err = ERR_NONE;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic is_last,
                               output t_dec_result r);
        logic [CP_W-1:0] cp_min;
        r = '0;
        r.string_end = is_last;
        // once an error is latched the rest of the string is not decoded
        if (first_err == ERR_NONE) begin
            if (cont_left == 2'd0) begin
                if (b < 8'h80) begin
                    if ((b < BYTE_SPACE && b != BYTE_TAB) || b == BYTE_DEL) begin
                        first_err = ERR_CONTROL;
                    end else begin
                        r.code_point = CP_W'(b);
                        r.char_done  = 1'b1;
                    end
                end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                    seq_len   = SEQ_LEN2;
                    cont_left = 2'd1;
                    cp_accum  = CP_W'(b[4:0]);
                end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                    seq_len   = SEQ_LEN3;
                    cont_left = 2'd2;
                    cp_accum  = CP_W'(b[3:0]);
                end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                    seq_len   = SEQ_LEN4;
                    cont_left = 2'd3;
                    cp_accum  = CP_W'(b[2:0]);
                end else begin
                    first_err = ERR_INVALID;
                end
            end else if (b[7:6] != CONT_TAG) begin
                first_err = ERR_INVALID;
            end else begin
                cp_accum  = {cp_accum[CP_W-7:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    cp_min = (seq_len == SEQ_LEN2) ? CP_MIN2 :
                             (seq_len == SEQ_LEN3) ? CP_MIN3 : CP_MIN4;
                    // overlong, above the unicode range, or a surrogate
                    if (cp_accum < cp_min || cp_accum > CP_MAX ||
                        (cp_accum >= SURR_LO && cp_accum <= SURR_HI)) begin
                        first_err = ERR_INVALID;
                    end else begin
                        r.code_point = cp_accum;
                        r.char_done  = 1'b1;
                    end
                end
            end
            if (first_err != ERR_NONE) begin
                cont_left = 2'd0;
                seq_len   = 3'd0;
                cp_accum  = '0;
            end
        end
        // string cut short in the middle of a sequence
        if (is_last && first_err == ERR_NONE && cont_left != 2'd0)
            first_err = ERR_INVALID;
        r.error_kind = first_err;
        if (is_last)
            clear_decoder();
    endtask

    always @(posedge i_clk) begin : monitor
        t_dec_result want;
        t_dec_result got;
        if (!i_rst_n) begin
            clear_decoder();
            decoded_q.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                decode_byte(i_s_axis_tdata[7:0], i_s_axis_tlast, want);
                decoded_q.insert(decoded_q.size(), want);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.code_point = i_m_axis_tdata[CP_W-1:0];
                got.char_done  = i_m_axis_tuser[0];
                got.error_kind = i_m_axis_tuser[2:1];
                got.string_end = i_m_axis_tlast;
                if (decoded_q.size() == 0) begin
                    $error("result beat with nothing expected: cp %h done %b err %0d end %b",
                           got.code_point, got.char_done, got.error_kind, got.string_end);
                    fails++;
                end else begin
                    want = decoded_q.pop_front();
                    if (got.code_point !== want.code_point) begin
                        $error("code_point: expected %h, got %h", want.code_point,
                               got.code_point);
                        fails++;
                    end
                    if (got.char_done !== want.char_done) begin
                        $error("char_done: expected %b, got %b", want.char_done,
                               got.char_done);
                        fails++;
                    end
                    if (got.error_kind !== want.error_kind) begin
                        $error("error_kind: expected %0d, got %0d", want.error_kind,
                               got.error_kind);
                        fails++;
                    end
                    if (got.string_end !== want.string_end) begin
                        $error("string_end: expected %b, got %b", want.string_end,
                               got.string_end);
                        fails++;
                    end
                end
            end
        end
        o_outstanding <= decoded_q.size();
        o_fail_count  <= fails;
    end

endmodule

### verif/utf8_validator_tb.sv
`timescale 1ns / 1ps
// utf-8 validator testbench top: clock, reset, byte strings, output backpressure, verdict
module utf8_validator_tb;
    import utf8v_pkg::*;

    localparam int N_BYTES    = 1600;
    localparam int HOLD_OFF   = 400;
    localparam int DRAIN_CYC  = 8;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;   // [7:0] byte_value
    logic                   i_s_axis_tlast;   // last_byte
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;   // [20:0] code_point, zero pad
    logic [OUT_TUSER_W-1:0] o_m_axis_tuser;   // [0] char_done, [2:1] error_kind
    logic                   o_m_axis_tlast;   // string_end

    int          fail_count;
    int          outstanding;
    int          snd_idle_pct;
    int          rcv_idle_pct;
    int          bytes_sent;
    logic        hold_off_req;
    logic [7:0]  str_bytes[$];

    utf8_validator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    utf8_validator_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tuser  (o_m_axis_tuser),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // output side: random stalls, plus one long hold-off on request
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_OFF - 1) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic is_last);
        logic hs;
        if ($urandom_range(99) < snd_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < snd_idle_pct) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= is_last;
        // tready is stable by the falling edge, so sample it there
        do begin
            @(negedge i_clk);
            hs = o_s_axis_tready;
            @(posedge i_clk);
        end while (!hs);
    endtask

    task automatic send_text();
        for (int k = 0; k < str_bytes.size(); k++)
            send_beat(str_bytes[k], k == str_bytes.size() - 1);
        bytes_sent += str_bytes.size();
        str_bytes.delete();
    endtask

    // append one byte to the string being built
    task automatic put_byte(input logic [7:0] b);
        str_bytes.insert(str_bytes.size(), b);
    endtask

    // encode any 21-bit value with a forced length, overlong or out of range allowed
    task automatic add_char(input logic [20:0] cp, input int len);
        case (len)
            1: put_byte(cp[7:0]);
            2: begin
                put_byte({3'b110, cp[10:6]});
                put_byte({CONT_TAG, cp[5:0]});
            end
            3: begin
                put_byte({4'b1110, cp[15:12]});
                put_byte({CONT_TAG, cp[11:6]});
                put_byte({CONT_TAG, cp[5:0]});
            end
            default: begin
                put_byte({5'b11110, cp[20:18]});
                put_byte({CONT_TAG, cp[17:12]});
                put_byte({CONT_TAG, cp[11:6]});
                put_byte({CONT_TAG, cp[5:0]});
            end
        endcase
    endtask

    task automatic add_valid_multi(input int len);
        logic [20:0] cp;
        case (len)
            2: cp = 21'($urandom_range(21'h7ff, 21'h80));
            3: begin
                cp = 21'($urandom_range(21'hffff, 21'h800));
                if (cp >= SURR_LO && cp <= SURR_HI)
                    cp = cp - 21'h1000;
            end
            default: cp = 21'($urandom_range(21'h10ffff, 21'h10000));
        endcase
        add_char(cp, len);
    endtask

    // mostly well-formed text, with some noise and broken sequences mixed in
    task automatic build_random_text();
        int          n_chars;
        int          pick;
        int          len;
        logic [7:0]  b;
        n_chars = $urandom_range(6, 1);
        for (int c = 0; c < n_chars; c++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                if ($urandom_range(19) == 0)
                    put_byte(BYTE_TAB);
                else
                    put_byte(8'($urandom_range(8'h7e, 8'h20)));
            end else if (pick < 44) begin
                if ($urandom_range(7) == 0)
                    put_byte(BYTE_DEL);
                else
                    put_byte(8'($urandom_range(8'h1f, 8'h00)));
            end else if (pick < 86) begin
                add_valid_multi($urandom_range(4, 2));
            end else if (pick < 90) begin
                put_byte(8'($urandom_range(255)));
            end else if (pick < 93) begin
                // good lead, then something that is not a continuation byte
                put_byte(8'($urandom_range(LEAD4_HI, LEAD2_LO)));
                b = 8'($urandom_range(255));
                if (b[7:6] == CONT_TAG)
                    b[6] = 1'b1;
                put_byte(b);
            end else if (pick < 97) begin
                case ($urandom_range(4))
                    0: add_char(21'($urandom_range(21'h7f)), 2);
                    1: add_char(21'($urandom_range(21'h7ff)), 3);
                    2: add_char(21'($urandom_range(21'hffff)), 4);
                    3: add_char(21'($urandom_range(SURR_HI, SURR_LO)), 3);
                    default: add_char(21'($urandom_range(21'h1fffff, 21'h110000)), 4);
                endcase
            end else begin
                // sequence missing its tail bytes
                len = $urandom_range(4, 2);
                add_valid_multi(len);
                repeat ($urandom_range(len - 1, 1)) str_bytes.delete(str_bytes.size() - 1);
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        hold_off_req    = 1'b0;
        bytes_sent      = 0;
        snd_idle_pct    = 10;
        rcv_idle_pct    = 87;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // control byte latched, later bytes not decoded
        str_bytes = '{BYTE_TAB, 8'h7e, 8'h1f, 8'h41};
        send_text();
        str_bytes = '{BYTE_DEL};
        send_text();
        // smallest 2- and 3-byte values, largest 4-byte value
        str_bytes = '{LEAD2_LO, 8'h80, LEAD3_LO, 8'ha0, 8'h80, LEAD4_HI, 8'h8f, 8'hbf, 8'hbf};
        send_text();
        // surrogate
        str_bytes = '{8'hed, 8'ha0, 8'h80};
        send_text();
        // above the unicode range
        str_bytes = '{LEAD4_HI, 8'h90, 8'h80, 8'h80};
        send_text();
        // sequence broken by an ascii byte
        str_bytes = '{8'hc3, 8'h41};
        send_text();
        // stray continuation byte, impossible lead
        str_bytes = '{8'h80};
        send_text();
        str_bytes = '{8'hff};
        send_text();
        // truncated by end of string
        str_bytes = '{LEAD4_LO, 8'h90};
        send_text();

        bytes_sent = 0;
        while (bytes_sent < N_BYTES) begin
            if (bytes_sent < N_BYTES / 3) begin
                snd_idle_pct = 10;
                rcv_idle_pct = 87;
            end else if (bytes_sent < 2 * N_BYTES / 3) begin
                snd_idle_pct = 87;
                rcv_idle_pct = 10;
            end else begin
                if (snd_idle_pct != 0)
                    hold_off_req = 1'b1;
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            build_random_text();
            send_text();
        end
        i_s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
